[design/byte_ring_fifo_with_peak_unit_macros.svh]
// assertion macros used by the design file brf_back.sv
`ifndef BYTE_RING_FIFO_WITH_PEAK_UNIT_MACROS_SVH
`define BYTE_RING_FIFO_WITH_PEAK_UNIT_MACROS_SVH

`ifndef SYNTH

// property that holds at every edge out of reset
`define BRF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// antecedent now, consequent in the cycle after
`define BRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BRF_ASSERT(lbl, clk, rstn, prop, msg)
`define BRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[design/brf_pkg.sv]
package brf_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = 13;
    localparam int DATA_W      = 8;
    localparam int LEN_W       = 7;
    localparam int REQ_W       = 2;
    localparam int MAX_BURST   = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] CAP_MAX       = CNT_W'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] CAP_MIN       = CNT_W'(1);
    localparam logic [LEN_W-1:0] MAX_BURST_LEN = LEN_W'(MAX_BURST);

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STATS = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

    typedef enum logic [1:0] {
        K_WRITE,
        K_READ,
        K_STATS,
        K_STATUS
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [DATA_W-1:0]  data;
        logic [LEN_W-1:0]   len;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic {
        BK_IDLE,
        BK_BURST
    } t_back_state;

endpackage

[design/brf_front.sv]
module brf_front
    import brf_pkg::*;
(
    input  logic              i_start,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [DATA_W-1:0] i_data_byte,
    input  logic [LEN_W-1:0]  i_read_len,
    input  t_q_status         i_q_status,
    output logic              o_busy,
    output logic              o_push,
    output t_cmd              o_cmd
);

    always_comb begin
        o_cmd.data = i_data_byte;
        // burst length clamped here so the back end never sees more than a burst
        o_cmd.len  = (i_read_len > MAX_BURST_LEN) ? MAX_BURST_LEN : i_read_len;
        unique case (i_req_type)
            REQ_WRITE: o_cmd.kind = K_WRITE;
            REQ_READ:  o_cmd.kind = K_READ;
            REQ_STATS: o_cmd.kind = K_STATS;
            REQ_NONE:  o_cmd.kind = K_STATUS;
            default:   o_cmd.kind = K_STATUS;
        endcase
    end

    assign o_busy = i_q_status.full;
    assign o_push = i_start & ~i_q_status.full;

endmodule

[design/brf_cmd_queue.sv]
module brf_cmd_queue
    import brf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push & ~o_status.full;
    assign w_pop  = i_pop & ~o_status.empty;
    assign o_head = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/brf_back.sv]
`include "byte_ring_fifo_with_peak_unit_macros.svh"

module brf_back
    import brf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_head,
    input  t_q_status         i_q_status,
    output logic              o_pop,
    input  logic              i_cfg_valid,
    input  logic [CNT_W-1:0]  i_cfg_data,
    output logic              o_cfg_ready,
    output logic              o_strobe,
    output logic [DATA_W-1:0] o_read_byte,
    output logic              o_byte_valid,
    output logic              o_accepted,
    output logic              o_last,
    output logic [CNT_W-1:0]  o_fill_count,
    output logic [CNT_W-1:0]  o_free_count,
    output logic [CNT_W-1:0]  o_peak_fill
);

    logic [DATA_W-1:0] mem_store [STORE_DEPTH];

    t_back_state       r_state, n_state;
    logic [CNT_W-1:0]  r_cap, n_cap;
    logic [ADDR_W-1:0] r_wpos, n_wpos;
    logic [ADDR_W-1:0] r_rpos, n_rpos;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_peak, n_peak;
    logic [LEN_W-1:0]  r_left, n_left;

    logic              r_strobe, n_strobe;
    logic              r_byte_valid, n_byte_valid;
    logic              r_accepted, n_accepted;
    logic              r_last, n_last;
    logic [CNT_W-1:0]  r_free_out, n_free_out;
    logic [CNT_W-1:0]  r_fill_out;
    logic [CNT_W-1:0]  r_peak_out;
    logic [DATA_W-1:0] r_rd_byte;

    logic              w_pop;
    logic              w_cfg_we;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [LEN_W-1:0]  w_burst_len;
    logic [ADDR_W-1:0] w_wpos_inc;
    logic [ADDR_W-1:0] w_rpos_inc;
    logic [CNT_W-1:0]  w_cfg_cap;

    assign w_pop       = (r_state == BK_IDLE) & ~i_q_status.empty;
    assign o_pop       = w_pop;
    // idle means nothing queued, no burst and the last result already strobed
    assign o_cfg_ready = (r_state == BK_IDLE) & i_q_status.empty & ~r_strobe;
    assign w_cfg_we    = i_cfg_valid & o_cfg_ready;

    assign w_burst_len = ({{(CNT_W-LEN_W){1'b0}}, i_head.len} < r_fill) ?
                         i_head.len : LEN_W'(r_fill);
    assign w_wpos_inc  = ((CNT_W'(r_wpos) + CNT_W'(1)) >= r_cap) ? '0 : r_wpos + 1'b1;
    assign w_rpos_inc  = ((CNT_W'(r_rpos) + CNT_W'(1)) >= r_cap) ? '0 : r_rpos + 1'b1;
    assign w_cfg_cap   = (i_cfg_data == '0) ? CAP_MIN :
                         (i_cfg_data > CAP_MAX) ? CAP_MAX : i_cfg_data;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (w_pop && i_head.kind == K_READ && w_burst_len > LEN_W'(1)) begin
                    n_state = BK_BURST;
                end
            end
            BK_BURST: begin
                if (r_left == LEN_W'(1)) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        n_cap        = r_cap;
        n_wpos       = r_wpos;
        n_rpos       = r_rpos;
        n_fill       = r_fill;
        n_peak       = r_peak;
        n_left       = r_left;
        n_strobe     = 1'b0;
        n_byte_valid = 1'b0;
        n_accepted   = 1'b0;
        n_last       = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_re     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (w_pop) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    unique case (i_head.kind)
                        K_WRITE: begin
                            if (r_fill < r_cap) begin
                                w_mem_we   = 1'b1;
                                n_accepted = 1'b1;
                                n_wpos     = w_wpos_inc;
                                n_fill     = r_fill + 1'b1;
                                if (r_fill + 1'b1 > r_peak) begin
                                    n_peak = r_fill + 1'b1;
                                end
                            end
                        end
                        K_READ: begin
                            // first beat of the burst goes out right away
                            if (w_burst_len != '0) begin
                                w_mem_re     = 1'b1;
                                n_byte_valid = 1'b1;
                                n_last       = (w_burst_len == LEN_W'(1));
                                n_rpos       = w_rpos_inc;
                                n_fill       = r_fill - 1'b1;
                                n_left       = w_burst_len - 1'b1;
                            end
                        end
                        K_STATS: n_peak = r_fill;
                        K_STATUS: n_peak = r_peak;
                        default: n_peak = r_peak;
                    endcase
                end else if (w_cfg_we) begin
                    n_cap  = w_cfg_cap;
                    n_wpos = '0;
                    n_rpos = '0;
                    n_fill = '0;
                    n_peak = '0;
                end
            end
            BK_BURST: begin
                w_mem_re     = 1'b1;
                n_strobe     = 1'b1;
                n_byte_valid = 1'b1;
                n_last       = (r_left == LEN_W'(1));
                n_rpos       = w_rpos_inc;
                n_fill       = r_fill - 1'b1;
                n_left       = r_left - 1'b1;
            end
            default: n_left = r_left;
        endcase
        n_free_out = (r_cap >= n_fill) ? r_cap - n_fill : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_store[r_wpos] <= i_head.data;
        end
        if (w_mem_re) begin
            r_rd_byte <= mem_store[r_rpos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_cap    <= CAP_MAX;
            r_wpos   <= '0;
            r_rpos   <= '0;
            r_fill   <= '0;
            r_peak   <= '0;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cap    <= n_cap;
            r_wpos   <= n_wpos;
            r_rpos   <= n_rpos;
            r_fill   <= n_fill;
            r_peak   <= n_peak;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte_valid <= n_byte_valid;
        r_accepted   <= n_accepted;
        r_last       <= n_last;
        r_fill_out   <= n_fill;
        r_free_out   <= n_free_out;
        r_peak_out   <= n_peak;
    end

    assign o_strobe     = r_strobe;
    assign o_read_byte  = r_byte_valid ? r_rd_byte : '0;
    assign o_byte_valid = r_byte_valid;
    assign o_accepted   = r_accepted;
    assign o_last       = r_last;
    assign o_fill_count = r_fill_out;
    assign o_free_count = r_free_out;
    assign o_peak_fill  = r_peak_out;

    `BRF_ASSERT(a_fill_le_cap, i_clk, i_rst_n, r_fill <= r_cap, "fill above capacity")
    `BRF_ASSERT(a_peak_ge_fill, i_clk, i_rst_n, r_peak >= r_fill, "peak below fill")
    `BRF_ASSERT(a_burst_left, i_clk, i_rst_n, (r_state != BK_BURST) || (r_left != '0), "burst with no bytes left")
    `BRF_ASSERT_NEXT(a_read_result, i_clk, i_rst_n, w_mem_re, r_strobe && r_byte_valid, "read beat without result")
    `BRF_ASSERT(a_fill_report, i_clk, i_rst_n, !r_strobe || (r_fill_out == r_fill), "reported fill differs")

endmodule

[design/byte_ring_fifo_with_peak_unit.sv]
// a taken request waits in the command queue; its result strobes after the execute unit pops it
// throughput: write, stats and status requests one per cycle when no burst runs; a read
// holds the execute unit for its whole burst, one byte per cycle out of the store port
// a two-entry command queue lets requests be taken while a burst runs
// reset: synchronous active low, capacity 4096, buffer empty, peak zero, no clearing pass
// capacity writes are taken once the queue is drained, no burst runs and the last result has strobed
module byte_ring_fifo_with_peak_unit
    import brf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [DATA_W-1:0] i_data_byte,
    input  logic [LEN_W-1:0]  i_read_len,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data,
    output logic              o_strobe,
    output logic [DATA_W-1:0] o_read_byte,
    output logic              o_byte_valid,
    output logic              o_accepted,
    output logic              o_last,
    output logic [CNT_W-1:0]  o_fill_count,
    output logic [CNT_W-1:0]  o_free_count,
    output logic [CNT_W-1:0]  o_peak_fill
);

    t_cmd      w_in_cmd;
    t_cmd      w_head;
    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;

    brf_front u_front (
        .i_start     (i_start),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .i_read_len  (i_read_len),
        .i_q_status  (w_q_status),
        .o_busy      (o_busy),
        .o_push      (w_push),
        .o_cmd       (w_in_cmd)
    );

    brf_cmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_in_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    brf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_q_status   (w_q_status),
        .o_pop        (w_pop),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .o_strobe     (o_strobe),
        .o_read_byte  (o_read_byte),
        .o_byte_valid (o_byte_valid),
        .o_accepted   (o_accepted),
        .o_last       (o_last),
        .o_fill_count (o_fill_count),
        .o_free_count (o_free_count),
        .o_peak_fill  (o_peak_fill)
    );

endmodule
